[rtl/qbp_pkg.sv]
// package: shared constants and widths for the quad buffer pass-through block
`default_nettype none
package qbp_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned DAC_W    = 15;
  localparam int unsigned GAIN_W   = 4;
  localparam int unsigned ROLE_W   = 2;

  localparam logic [WORD_W-1:0] DATA_MASK  = 16'h0FFF;
  localparam logic [DAC_W-1:0]  CTRL_BITS  = 15'h7000;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd3;

  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_PROCESS = 1'b1;

endpackage
`default_nettype wire

[rtl/qbp_if.sv]
// interfaces: request and result channels with valid/ready handshake
`default_nettype none
interface qbp_req_if
  import qbp_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output req_type, output adc_sample, input ready);
  modport sink   (input valid, input req_type, input adc_sample, output ready);
endinterface

interface qbp_rsp_if
  import qbp_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [DAC_W-1:0] dac_word;
  logic             dac_valid;
  logic             block_done;
  logic             overrun;
  logic             processed;
  logic             pending;

  modport source (output valid, output dac_word, output dac_valid, output block_done,
                  output overrun, output processed, output pending, input ready);
  modport sink   (input valid, input dac_word, input dac_valid, input block_done,
                  input overrun, input processed, input pending, output ready);
endinterface
`default_nettype wire

[rtl/quad_buffer_block_passthrough_unit.sv]
// top level: four-buffer block audio pass-through around one sample memory
//
//   channel  dir  handshake            payload
//   req      in   valid/ready          req_type, adc_sample
//   rsp      out  valid/ready          dac_word, dac_valid, block_done, overrun,
//                                      processed, pending
//   cfg      in   cfg_we               cfg_wdata (block_gain)
//
// a sample tick reads the playing entry from memory, then emits the result.
// a process item with a block pending runs the gain loop: it reads one ready entry and
// writes one working entry per cycle through the single memory port pair.
// after reset a clearing pass zeroes all 4*BLOCK_LEN entries; req is held off.
// the next item is accepted while a result waits; it finishes once rsp drains.
`default_nettype none
module quad_buffer_block_passthrough_unit
  import qbp_pkg::*;
#(
  parameter int unsigned BLOCK_LEN = 128
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [GAIN_W-1:0] cfg_wdata,
  qbp_req_if.sink                req,
  qbp_rsp_if.source              rsp
);

  localparam int unsigned DEPTH  = 4 * BLOCK_LEN;
  localparam int unsigned POS_W  = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] BLK       = ADDR_W'(BLOCK_LEN);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(BLOCK_LEN - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PROC  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data;

  logic [2:0]        state;
  logic [ADDR_W-1:0] clr_addr;
  logic [ROLE_W-1:0] fill_role, ready_role, work_role, play_role;
  logic [POS_W-1:0]  position;
  logic              block_pending;
  logic [GAIN_W-1:0] block_gain;
  logic [POS_W-1:0]  proc_idx;
  logic [POS_W-1:0]  wr_idx;
  logic              wr_pend;

  logic res_dac_valid, res_done, res_over, res_proc;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic              req_fire;
  logic              rsp_free;
  logic              pos_last;
  logic [WORD_W+GAIN_W-1:0] product;

  function automatic logic [ADDR_W-1:0] slot(input logic [ROLE_W-1:0] role,
                                             input logic [POS_W-1:0] idx);
    slot = ADDR_W'(role) * BLK + ADDR_W'(idx);
  endfunction

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign rsp_free  = !rsp.valid || rsp.ready;
  assign pos_last  = (position == LAST_POS);
  assign product   = rd_data * block_gain;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = slot(play_role, position);
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (wr_pend) begin
      mem_we    = 1'b1;
      mem_waddr = slot(work_role, wr_idx);
      mem_wdata = product[WORD_W-1:0];
    end else if (req_fire && req.req_type == REQ_SAMPLE) begin
      mem_we    = 1'b1;
      mem_waddr = slot(fill_role, position);
      mem_wdata = WORD_W'(req.adc_sample);
      mem_re    = 1'b1;
    end
    if (state == S_PROC) begin
      mem_re    = 1'b1;
      mem_raddr = slot(ready_role, proc_idx);
    end
  end

  // fill and play, ready and work are always distinct buffers: no same-entry overlap
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_gain <= GAIN_RESET;
    end else if (cfg_we) begin
      block_gain <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      fill_role     <= 2'd0;
      ready_role    <= 2'd1;
      work_role     <= 2'd2;
      play_role     <= 2'd3;
      position      <= '0;
      block_pending <= 1'b0;
      proc_idx      <= '0;
      wr_idx        <= '0;
      wr_pend       <= 1'b0;
      rsp.valid     <= 1'b0;
    end else begin
      wr_pend <= (state == S_PROC);
      wr_idx  <= proc_idx;
      if (state == S_EMIT && rsp_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            if (req.req_type == REQ_SAMPLE) begin
              state <= S_EMIT;
              if (pos_last) begin
                position      <= '0;
                fill_role     <= ready_role;
                ready_role    <= fill_role;
                work_role     <= play_role;
                play_role     <= work_role;
                block_pending <= 1'b1;
              end else begin
                position <= position + 1'b1;
              end
            end else if (block_pending) begin
              block_pending <= 1'b0;
              proc_idx      <= '0;
              state         <= S_PROC;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_PROC: begin
          proc_idx <= proc_idx + 1'b1;
          if (proc_idx == LAST_POS) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result flags captured at accept, emitted with the read data
  always_ff @(posedge clk) begin
    if (req_fire) begin
      res_dac_valid <= (req.req_type == REQ_SAMPLE);
      res_done      <= (req.req_type == REQ_SAMPLE) && pos_last;
      res_over      <= (req.req_type == REQ_SAMPLE) && pos_last && block_pending;
      res_proc      <= (req.req_type == REQ_PROCESS) && block_pending;
    end
    if (state == S_EMIT && rsp_free) begin
      rsp.dac_word   <= res_dac_valid ? (CTRL_BITS | DAC_W'(rd_data & DATA_MASK)) : '0;
      rsp.dac_valid  <= res_dac_valid;
      rsp.block_done <= res_done;
      rsp.overrun    <= res_over;
      rsp.processed  <= res_proc;
      rsp.pending    <= block_pending;
    end
  end

endmodule
`default_nettype wire

[test/qbp_checker.sv]
// checker: predicts each dac transaction from the accepted requests and compares it with the block
module qbp_checker
  import qbp_pkg::*;
#(
  parameter int unsigned BLOCK_LEN = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [GAIN_W-1:0] cfg_wdata,
  qbp_req_if                req_mon,
  qbp_rsp_if                rsp_mon,
  output int unsigned       backlog,
  output int unsigned       mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DAC_W-1:0] dac_word;
    logic             dac_valid;
    logic             block_done;
    logic             overrun;
    logic             processed;
    logic             pending;
  } dac_result_t;

  localparam int unsigned STORE_DEPTH = 4 * BLOCK_LEN;

  logic [WORD_W-1:0] sample_mem [STORE_DEPTH];
  logic [ROLE_W-1:0] fill_buf;
  logic [ROLE_W-1:0] ready_buf;
  logic [ROLE_W-1:0] work_buf;
  logic [ROLE_W-1:0] play_buf;
  int unsigned       fill_pos;
  logic              block_waiting;
  logic [GAIN_W-1:0] gain;
  dac_result_t       dac_results_due [$];

  function automatic int unsigned mem_addr(input logic [ROLE_W-1:0] buf_id,
                                           input int unsigned idx);
    return buf_id * BLOCK_LEN + idx;
  endfunction

  function automatic string show(input dac_result_t r);
    return $sformatf("word=%h dac_valid=%b done=%b overrun=%b processed=%b pending=%b",
                     r.dac_word, r.dac_valid, r.block_done, r.overrun, r.processed,
                     r.pending);
  endfunction

  // one request against the buffer state; returns the dac transaction it causes
  function automatic dac_result_t advance_buffers(input logic kind,
                                                  input logic [SAMPLE_W-1:0] smp);
    dac_result_t              res;
    logic [ROLE_W-1:0]        swap;
    logic [WORD_W-1:0]        played;
    logic [WORD_W+GAIN_W-1:0] product;
    res = '0;
    if (kind == REQ_SAMPLE) begin
      sample_mem[mem_addr(fill_buf, fill_pos)] = WORD_W'(smp);
      played = sample_mem[mem_addr(play_buf, fill_pos)];
      res.dac_word  = CTRL_BITS | DAC_W'(played & DATA_MASK);
      res.dac_valid = 1'b1;
      fill_pos++;
      if (fill_pos == BLOCK_LEN) begin
        fill_pos = 0;
        res.overrun    = block_waiting;
        res.block_done = 1'b1;
        swap = fill_buf;
        fill_buf = ready_buf;
        ready_buf = swap;
        swap = work_buf;
        work_buf = play_buf;
        play_buf = swap;
        block_waiting = 1'b1;
      end
    end else if (block_waiting) begin
      for (int unsigned i = 0; i < BLOCK_LEN; i++) begin
        product = sample_mem[mem_addr(ready_buf, i)] * gain;
        sample_mem[mem_addr(work_buf, i)] = product[WORD_W-1:0];
      end
      block_waiting = 1'b0;
      res.processed = 1'b1;
    end
    res.pending = block_waiting;
    return res;
  endfunction

  always @(posedge clk) begin
    dac_result_t seen;
    dac_result_t due;
    if (rst) begin
      for (int unsigned i = 0; i < STORE_DEPTH; i++) sample_mem[i] = '0;
      fill_buf = 2'd0;
      ready_buf = 2'd1;
      work_buf = 2'd2;
      play_buf = 2'd3;
      fill_pos = 0;
      block_waiting = 1'b0;
      gain = GAIN_RESET;
      dac_results_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) gain = cfg_wdata;
      // the response side goes first: a transaction at this edge belongs to an older request
      if (rsp_mon.valid && rsp_mon.ready) begin
        seen.dac_word   = rsp_mon.dac_word;
        seen.dac_valid  = rsp_mon.dac_valid;
        seen.block_done = rsp_mon.block_done;
        seen.overrun    = rsp_mon.overrun;
        seen.processed  = rsp_mon.processed;
        seen.pending    = rsp_mon.pending;
        if (dac_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: dac transaction with nothing due: %s", $time, show(seen));
        end else begin
          due = dac_results_due.pop_front();
          if (seen !== due) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: dac transaction mismatch", $time);
              $display("  expected %s", show(due));
              $display("  actual   %s", show(seen));
            end
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        dac_results_due.push_back(advance_buffers(req_mon.req_type, req_mon.adc_sample));
    end
    backlog <= dac_results_due.size();
  end

endmodule

[test/tb_top.sv]
// testbench top: clock, reset, gain writes and request traffic around the pass-through block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import qbp_pkg::*;

  localparam int unsigned BLOCK_LEN   = 128;
  localparam int unsigned PHASE_TICKS = 225;
  // clearing pass plus one block process plus the longest gaps, several times over
  localparam int unsigned STALL_LIMIT = 4 * (5 * BLOCK_LEN + 16);

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [GAIN_W-1:0] cfg_wdata;
  logic              no_idle;
  logic [2:0]        stall_left;
  int unsigned       backlog;
  int unsigned       mismatches;
  int unsigned       quiet_cycles = 0;
  int unsigned       ticks_sent;

  qbp_req_if req_ch ();
  qbp_rsp_if rsp_ch ();

  quad_buffer_block_passthrough_unit #(.BLOCK_LEN(BLOCK_LEN)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  qbp_checker #(.BLOCK_LEN(BLOCK_LEN)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req_mon    (req_ch),
    .rsp_mon    (rsp_ch),
    .backlog    (backlog),
    .mismatches (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // response side back-pressure in random bursts, started only while no_idle is low
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= '0;
    end else if (stall_left != 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= stall_left - 1'b1;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= 3'($urandom_range(0, 5));
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic kind, input logic [SAMPLE_W-1:0] smp);
    int unsigned gap;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 6);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.adc_sample <= smp;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (kind == REQ_SAMPLE) ticks_sent++;
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] g);
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // per block: usually one process somewhere in it, sometimes none (overrun), sometimes two
  task automatic run_blocks(input int unsigned ticks);
    int unsigned         plan;
    int unsigned         proc_at;
    logic [SAMPLE_W-1:0] smp;
    plan = 0;
    proc_at = 0;
    for (int unsigned n = 0; n < ticks; n++) begin
      if (n == 0 || ticks_sent % BLOCK_LEN == 0) begin
        plan = $urandom_range(0, 9);
        proc_at = $urandom_range(0, BLOCK_LEN - 1);
      end
      if (plan >= 3 && ticks_sent % BLOCK_LEN == proc_at) begin
        send_item(REQ_PROCESS, SAMPLE_W'($urandom_range(0, 4095)));
        if (plan >= 8) send_item(REQ_PROCESS, SAMPLE_W'($urandom_range(0, 4095)));
      end
      if ($urandom_range(0, 99) == 0) send_item(REQ_PROCESS, '0);
      case ($urandom_range(0, 15))
        0:       smp = '0;
        1:       smp = '1;
        default: smp = SAMPLE_W'($urandom_range(0, 4095));
      endcase
      send_item(REQ_SAMPLE, smp);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    no_idle = 1'b0;
    ticks_sent = 0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_SAMPLE;
    req_ch.adc_sample = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // process with nothing pending, then field extremes and bit patterns at the reset gain
    send_item(REQ_PROCESS, '0);
    send_item(REQ_SAMPLE, 12'h000);
    send_item(REQ_SAMPLE, 12'hFFF);
    send_item(REQ_SAMPLE, 12'h800);
    send_item(REQ_SAMPLE, 12'h001);
    send_item(REQ_SAMPLE, 12'hAAA);
    send_item(REQ_SAMPLE, 12'h555);
    send_item(REQ_SAMPLE, 12'h7FF);
    send_item(REQ_SAMPLE, 12'hFFE);
    send_item(REQ_PROCESS, 12'hFFF);
    send_item(REQ_SAMPLE, 12'hF0F);
    send_item(REQ_SAMPLE, 12'h0F0);
    send_item(REQ_PROCESS, 12'h123);
    send_item(REQ_SAMPLE, 12'hFFF);
    send_item(REQ_SAMPLE, 12'h000);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0:       write_gain(4'd15);
        1:       write_gain(4'd0);
        2:       write_gain(GAIN_W'($urandom_range(1, 14)));
        default: write_gain(GAIN_W'($urandom_range(0, 15)));
      endcase
      no_idle = (ph == 3);
      run_blocks(PHASE_TICKS);
    end

    settle();
    repeat (BLOCK_LEN + 4) @(posedge clk);
    if (mismatches == 0 && backlog == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
